### rtl/core/rpfm_pkg.sv
// rpfm_pkg: shared types and constants for the first-match route policy table
// holds the node record, route record, op codes and sequencer states
// no dependencies
package rpfm_pkg;

  localparam int unsigned DEF_MAX_NODES = 16;
  localparam int unsigned ACTIVE_W      = 5;
  localparam int unsigned SLOT_W        = 4;
  localparam int unsigned HALF_W        = 64;
  localparam int unsigned LEN_W         = 8;
  localparam int unsigned ATTR_W        = 32;
  localparam int unsigned WIDE_CNT_W    = 9;

  localparam logic [LEN_W-1:0] IPV4_MAX_LEN = 8'd32;
  localparam logic [LEN_W-1:0] IPV6_MAX_LEN = 8'd128;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } op_e;

  typedef enum logic {
    FAM_IPV4 = 1'b0,
    FAM_IPV6 = 1'b1
  } family_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HOLD
  } state_e;

  typedef struct packed {
    logic              test_on;
    logic              allow;
    logic              family;
    logic [LEN_W-1:0]  rule_len;
    logic [HALF_W-1:0] addr_high;
    logic [HALF_W-1:0] addr_low;
    logic [ATTR_W-1:0] attr_mask;
    logic [ATTR_W-1:0] pref;
    logic [ATTR_W-1:0] metric;
  } node_t;

  typedef struct packed {
    logic              family;
    logic [HALF_W-1:0] addr_high;
    logic [HALF_W-1:0] addr_low;
    logic [LEN_W-1:0]  length;
  } route_t;

endpackage

### rtl/core/rpfm_node_mem.sv
// rpfm_node_mem: policy node store, one write port and one registered read port
// uses rpfm_pkg::node_t
module rpfm_node_mem #(
  parameter int unsigned MAX_NODES = rpfm_pkg::DEF_MAX_NODES,
  parameter int unsigned IDX_W     = 4
) (
  input  logic                 clk_i,
  input  logic                 wr_en_i,
  input  logic [IDX_W-1:0]     wr_addr_i,
  input  rpfm_pkg::node_t      wr_data_i,
  input  logic                 rd_en_i,
  input  logic [IDX_W-1:0]     rd_addr_i,
  output rpfm_pkg::node_t      rd_data_o
);

  rpfm_pkg::node_t mem_q [MAX_NODES];
  rpfm_pkg::node_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### rtl/core/rpfm_match_unit.sv
// rpfm_match_unit: prefix compare of one policy node against the route
// one masked 128-bit compare, shared by every step of the scan; uses rpfm_pkg
module rpfm_match_unit (
  input  rpfm_pkg::node_t  node_i,
  input  rpfm_pkg::route_t route_i,
  output logic             match_o
);

  function automatic logic [rpfm_pkg::HALF_W-1:0] lead_mask(input logic [6:0] n);
    logic [rpfm_pkg::HALF_W-1:0] m;
    if (n == 7'd0) begin
      m = '0;
    end else if (n >= 7'd64) begin
      m = '1;
    end else begin
      m = {rpfm_pkg::HALF_W{1'b1}} << (7'd64 - n);
    end
    return m;
  endfunction

  logic [rpfm_pkg::LEN_W-1:0]  nlen;
  logic [rpfm_pkg::LEN_W-1:0]  nlen_low;
  logic [rpfm_pkg::HALF_W-1:0] mask_hi;
  logic [rpfm_pkg::HALF_W-1:0] mask_lo;
  logic                        bits_eq;

  always_comb begin
    nlen = node_i.rule_len;
    if (node_i.family == rpfm_pkg::FAM_IPV4 && nlen > rpfm_pkg::IPV4_MAX_LEN) begin
      nlen = rpfm_pkg::IPV4_MAX_LEN;
    end
    if (nlen > rpfm_pkg::IPV6_MAX_LEN) begin
      nlen = rpfm_pkg::IPV6_MAX_LEN;
    end
    nlen_low = nlen - 8'd64;
    mask_hi  = (nlen >= 8'd64) ? '1 : lead_mask(nlen[6:0]);
    mask_lo  = (nlen > 8'd64) ? lead_mask(nlen_low[6:0]) : '0;
    bits_eq  = (((node_i.addr_high ^ route_i.addr_high) & mask_hi) == '0) &&
               (((node_i.addr_low ^ route_i.addr_low) & mask_lo) == '0);
    if (!node_i.test_on) begin
      match_o = 1'b1;
    end else begin
      match_o = (node_i.family == route_i.family) && (route_i.length >= nlen) && bits_eq;
    end
  end

endmodule

### rtl/core/rpfm_seq.sv
// rpfm_seq: scan sequencer, walks the node store one node per cycle
// holds the route, the scan index, the pending result and the output register; uses rpfm_pkg
module rpfm_seq #(
  parameter int unsigned IDX_W = 4,
  parameter int unsigned CNT_W = 5
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              op_i,
  input  rpfm_pkg::route_t                  route_i,
  input  logic [CNT_W-1:0]                  count_i,
  output logic                              rd_en_o,
  output logic [IDX_W-1:0]                  rd_addr_o,
  input  rpfm_pkg::node_t                   node_i,
  input  logic                              match_i,
  output rpfm_pkg::route_t                  route_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              verdict_o,
  output logic [rpfm_pkg::ATTR_W-1:0]       out_attr_mask_o,
  output logic [rpfm_pkg::ATTR_W-1:0]       out_pref_o,
  output logic [rpfm_pkg::ATTR_W-1:0]       out_metric_o
);

  rpfm_pkg::state_e state_q, state_d;
  logic [CNT_W-1:0] iss_q, iss_d;
  logic             rvld_q, rvld_d;
  logic             out_valid_q, out_valid_d;

  rpfm_pkg::route_t            route_q, route_d;
  logic                        res_verdict_q, res_verdict_d;
  logic [rpfm_pkg::ATTR_W-1:0] res_attr_q, res_attr_d;
  logic [rpfm_pkg::ATTR_W-1:0] res_pref_q, res_pref_d;
  logic [rpfm_pkg::ATTR_W-1:0] res_metric_q, res_metric_d;
  logic                        out_verdict_q, out_verdict_d;
  logic [rpfm_pkg::ATTR_W-1:0] out_attr_q, out_attr_d;
  logic [rpfm_pkg::ATTR_W-1:0] out_pref_q, out_pref_d;
  logic [rpfm_pkg::ATTR_W-1:0] out_metric_q, out_metric_d;

  logic finish;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rpfm_pkg::ST_IDLE;
      iss_q       <= '0;
      rvld_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      iss_q       <= iss_d;
      rvld_q      <= rvld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    route_q       <= route_d;
    res_verdict_q <= res_verdict_d;
    res_attr_q    <= res_attr_d;
    res_pref_q    <= res_pref_d;
    res_metric_q  <= res_metric_d;
    out_verdict_q <= out_verdict_d;
    out_attr_q    <= out_attr_d;
    out_pref_q    <= out_pref_d;
    out_metric_q  <= out_metric_d;
  end

  always_comb begin
    state_d       = state_q;
    iss_d         = iss_q;
    rvld_d        = 1'b0;
    route_d       = route_q;
    res_verdict_d = res_verdict_q;
    res_attr_d    = res_attr_q;
    res_pref_d    = res_pref_q;
    res_metric_d  = res_metric_q;
    out_verdict_d = out_verdict_q;
    out_attr_d    = out_attr_q;
    out_pref_d    = out_pref_q;
    out_metric_d  = out_metric_q;
    out_valid_d   = out_valid_q & ~out_ready_i;
    in_ready_o    = 1'b0;
    rd_en_o       = 1'b0;
    finish        = 1'b0;

    unique case (state_q)
      rpfm_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && op_i == rpfm_pkg::OP_EVAL) begin
          route_d = route_i;
          iss_d   = '0;
          if (count_i == '0) begin
            // empty table scan: deny with zero attributes
            res_verdict_d = 1'b0;
            res_attr_d    = '0;
            res_pref_d    = '0;
            res_metric_d  = '0;
            state_d       = rpfm_pkg::ST_HOLD;
          end else begin
            state_d = rpfm_pkg::ST_SCAN;
          end
        end
      end
      rpfm_pkg::ST_SCAN: begin
        // read data belongs to node iss_q-1
        if (rvld_q && match_i) begin
          finish        = 1'b1;
          res_verdict_d = node_i.allow;
          res_attr_d    = node_i.allow ? node_i.attr_mask : '0;
          res_pref_d    = node_i.allow ? node_i.pref : '0;
          res_metric_d  = node_i.allow ? node_i.metric : '0;
        end else if (rvld_q && iss_q == count_i) begin
          finish        = 1'b1;
          res_verdict_d = 1'b0;
          res_attr_d    = '0;
          res_pref_d    = '0;
          res_metric_d  = '0;
        end
        if (finish) begin
          state_d = rpfm_pkg::ST_HOLD;
        end else if (iss_q < count_i) begin
          rd_en_o = 1'b1;
          iss_d   = iss_q + 1'b1;
          rvld_d  = 1'b1;
        end
      end
      rpfm_pkg::ST_HOLD: begin
        if (!out_valid_q || out_ready_i) begin
          out_verdict_d = res_verdict_q;
          out_attr_d    = res_attr_q;
          out_pref_d    = res_pref_q;
          out_metric_d  = res_metric_q;
          out_valid_d   = 1'b1;
          state_d       = rpfm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rpfm_pkg::ST_IDLE;
      end
    endcase
  end

  assign rd_addr_o       = iss_q[IDX_W-1:0];
  assign route_o         = route_q;
  assign out_valid_o     = out_valid_q;
  assign verdict_o       = out_verdict_q;
  assign out_attr_mask_o = out_attr_q;
  assign out_pref_o      = out_pref_q;
  assign out_metric_o    = out_metric_q;

endmodule

### rtl/core/route_policy_first_match.sv
// route_policy_first_match: a load transaction writes one node.
// an evaluate transaction scans the node store one node per cycle through one
// compare unit until the first matching node or the last active node; an empty scan
// goes straight to the result hold state; not ready until the result is registered.
// reset clears the control state and active_nodes; node contents are undefined until loaded
module route_policy_first_match #(
  parameter int unsigned MAX_NODES = rpfm_pkg::DEF_MAX_NODES
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [rpfm_pkg::ACTIVE_W-1:0]        cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 op_i,
  input  logic [rpfm_pkg::SLOT_W-1:0]          slot_i,
  input  logic                                 prefix_test_on_i,
  input  logic                                 allow_i,
  input  logic                                 addr_family_i,
  input  logic [rpfm_pkg::HALF_W-1:0]          addr_high_i,
  input  logic [rpfm_pkg::HALF_W-1:0]          addr_low_i,
  input  logic [rpfm_pkg::LEN_W-1:0]           length_i,
  input  logic [rpfm_pkg::ATTR_W-1:0]          attr_mask_i,
  input  logic [rpfm_pkg::ATTR_W-1:0]          pref_value_i,
  input  logic [rpfm_pkg::ATTR_W-1:0]          metric_value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 verdict_o,
  output logic [rpfm_pkg::ATTR_W-1:0]          out_attr_mask_o,
  output logic [rpfm_pkg::ATTR_W-1:0]          out_pref_o,
  output logic [rpfm_pkg::ATTR_W-1:0]          out_metric_o
);

  localparam int unsigned IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_NODES + 1);
  localparam int unsigned WW    = rpfm_pkg::WIDE_CNT_W;

  logic [rpfm_pkg::ACTIVE_W-1:0] active_q;
  logic [WW-1:0]                 active_wide;
  logic [WW-1:0]                 count_wide;
  logic [WW-1:0]                 slot_wide;
  logic                          slot_ok;
  logic                          wr_en;
  rpfm_pkg::node_t               wr_node;
  rpfm_pkg::node_t               rd_node;
  rpfm_pkg::route_t              in_route;
  rpfm_pkg::route_t              scan_route;
  logic                          rd_en;
  logic [IDX_W-1:0]              rd_addr;
  logic                          match;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
    end else if (cfg_we_i) begin
      active_q <= cfg_wdata_i;
    end
  end

  // saturate the scan length at the table depth
  assign active_wide = WW'(active_q);
  assign count_wide  = (active_wide > WW'(MAX_NODES)) ? WW'(MAX_NODES) : active_wide;

  // loads beyond the table depth are dropped
  assign slot_wide = WW'(slot_i);
  assign slot_ok   = slot_wide < WW'(MAX_NODES);
  assign wr_en     = in_valid_i && in_ready_o && (op_i == rpfm_pkg::OP_LOAD) && slot_ok;

  assign wr_node = '{
    test_on:   prefix_test_on_i,
    allow:     allow_i,
    family:    addr_family_i,
    rule_len:  length_i,
    addr_high: addr_high_i,
    addr_low:  addr_low_i,
    attr_mask: attr_mask_i,
    pref:      pref_value_i,
    metric:    metric_value_i
  };

  assign in_route = '{
    family:    addr_family_i,
    addr_high: addr_high_i,
    addr_low:  addr_low_i,
    length:    length_i
  };

  rpfm_node_mem #(
    .MAX_NODES (MAX_NODES),
    .IDX_W     (IDX_W)
  ) u_node_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (slot_wide[IDX_W-1:0]),
    .wr_data_i (wr_node),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_node)
  );

  rpfm_match_unit u_match_unit (
    .node_i  (rd_node),
    .route_i (scan_route),
    .match_o (match)
  );

  rpfm_seq #(
    .IDX_W (IDX_W),
    .CNT_W (CNT_W)
  ) u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .op_i            (op_i),
    .route_i         (in_route),
    .count_i         (count_wide[CNT_W-1:0]),
    .rd_en_o         (rd_en),
    .rd_addr_o       (rd_addr),
    .node_i          (rd_node),
    .match_i         (match),
    .route_o         (scan_route),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .verdict_o       (verdict_o),
    .out_attr_mask_o (out_attr_mask_o),
    .out_pref_o      (out_pref_o),
    .out_metric_o    (out_metric_o)
  );

endmodule
